### rtl/fll_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// fll_pkg
// Shared widths, register indexes, the cell link type and Q15 helpers for
// the lattice filter.
// ============================================================================
package fll_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int COEFF_W        = 16;
    localparam int COUNT_W        = 4;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 64;
    localparam int COEFF_PER_WORD = CFG_DATA_W / COEFF_W;
    localparam int MAX_STAGES_DEF = 8;
    localparam int Q15_SHIFT      = 15;
    localparam int PROD_W         = SAMPLE_W + COEFF_W;
    localparam int TERM_W         = PROD_W - Q15_SHIFT;
    localparam int SUM_W          = TERM_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_STAGE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_LOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_HIGH  = 2'd2;

    localparam logic [COUNT_W-1:0] STAGE_COUNT_RST = 4'd1;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(32768);

    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] fwd;
        logic signed [SAMPLE_W-1:0] bwd;
        logic                       last;
    } fll_link_t;

    function automatic logic signed [SAMPLE_W-1:0] sat16(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SAMPLE_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[SAMPLE_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[SAMPLE_W-1:0];
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/fll_cell.sv
`timescale 1ns / 1ps
// ============================================================================
// fll_cell
// One lattice stage: holds its backward delay entry, computes the forward
// and backward updates and registers them for the next cell.
// ============================================================================
module fll_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                stage_en,
    input  logic signed [fll_pkg::COEFF_W-1:0]  coeff,
    input  fll_pkg::fll_link_t                  link_in,
    output fll_pkg::fll_link_t                  link_out
);
    import fll_pkg::*;

    logic signed [SAMPLE_W-1:0] delay_reg;
    fll_link_t                  link_reg;
    fll_link_t                  link_next;

    logic signed [PROD_W-1:0] prod_g;
    logic signed [PROD_W-1:0] prod_f;
    logic signed [TERM_W-1:0] term_g;
    logic signed [TERM_W-1:0] term_f;
    logic signed [SUM_W-1:0]  sum_f;
    logic signed [SUM_W-1:0]  sum_g;

    always_comb begin
        prod_g = delay_reg * coeff;
        prod_f = link_in.fwd * coeff;
        term_g = TERM_W'(prod_g >>> Q15_SHIFT);
        term_f = TERM_W'(prod_f >>> Q15_SHIFT);
        sum_f  = SUM_W'(link_in.fwd) + SUM_W'(term_g);
        sum_g  = SUM_W'(delay_reg) + SUM_W'(term_f);
        link_next = link_in;
        if (stage_en) begin
            link_next.fwd = sat16(sum_f);
            link_next.bwd = sat16(sum_g);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg.valid <= 1'b0;
            delay_reg      <= '0;
        end else begin
            link_reg.valid <= link_in.valid;
            if (link_in.valid) begin
                link_reg.fwd  <= link_next.fwd;
                link_reg.bwd  <= link_next.bwd;
                link_reg.last <= link_next.last;
                if (stage_en) begin
                    delay_reg <= link_in.bwd;
                end
            end
        end
    end

    assign link_out = link_reg;

endmodule

### rtl/fir_lattice_q15_filter.sv
`timescale 1ns / 1ps
// ============================================================================
// fir_lattice_q15_filter
// Q15 FIR lattice filter built as a chain of stage cells.
// ============================================================================
// Usage:
//   Input words (s_sample_in, s_block_end_in) are taken on s_valid & s_ready.
//   Each word yields one output word (m_sample_out, m_block_end_out) on
//   m_valid & m_ready. The block-end flag rides along unchanged.
//   Configuration: cfg_we writes cfg_data to register cfg_index
//   (0 stage count, 1 coefficients k0..k3, 2 coefficients k4..k7). The user
//   must write only while no word is in flight; the block does not check it.
//   The word walks the cell chain one stage per cycle, then the holding
//   and output registers; stages beyond the stage count pass it through
//   unchanged, so the whole chain of MAX_STAGES cells is always walked.
//   No new word is taken before the last leaves the chain: one word is in the
//   chain at a time, plus one result in the output register and one in the
//   holding register behind it.
//   Reset clears the delay line, sets stage count 1 and coefficients 0.
//   When the receiver stalls, the output word holds, a finished result waits
//   in the holding register and s_ready stays low until that register drains.
// ============================================================================
module fir_lattice_q15_filter #(
    parameter int MAX_STAGES = fll_pkg::MAX_STAGES_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [fll_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [fll_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [fll_pkg::SAMPLE_W-1:0]   s_sample_in,
    input  logic                                  s_block_end_in,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [fll_pkg::SAMPLE_W-1:0]   m_sample_out,
    output logic                                  m_block_end_out
);
    import fll_pkg::*;

    logic [COUNT_W-1:0]    stage_count_reg;
    logic [CFG_DATA_W-1:0] coeff_low_reg;
    logic [CFG_DATA_W-1:0] coeff_high_reg;

    logic                       busy_reg;
    logic                       pend_valid_reg;
    logic signed [SAMPLE_W-1:0] pend_sample_reg;
    logic                       pend_last_reg;
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_sample_reg;
    logic                       m_last_reg;

    logic      accept;
    logic      out_free;
    fll_link_t chain [MAX_STAGES+1];
    fll_link_t tail;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !busy_reg && (!pend_valid_reg || out_free);
    assign accept   = s_valid && s_ready;

    always_comb begin
        chain[0].valid = accept;
        chain[0].fwd   = s_sample_in;
        chain[0].bwd   = s_sample_in;
        chain[0].last  = s_block_end_in;
    end

    assign tail = chain[MAX_STAGES];

    for (genvar s = 0; s < MAX_STAGES; s++) begin : g_stage
        logic                      stage_en;
        logic signed [COEFF_W-1:0] coeff;

        assign stage_en = (s == 0) || (int'(stage_count_reg) > s);

        if (s < COEFF_PER_WORD) begin : g_low
            assign coeff = coeff_low_reg[COEFF_W*s +: COEFF_W];
        end else if (s < 2*COEFF_PER_WORD) begin : g_high
            assign coeff = coeff_high_reg[COEFF_W*(s-COEFF_PER_WORD) +: COEFF_W];
        end else begin : g_zero
            assign coeff = '0;
        end

        fll_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .stage_en (stage_en),
            .coeff    (coeff),
            .link_in  (chain[s]),
            .link_out (chain[s+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_count_reg <= STAGE_COUNT_RST;
            coeff_low_reg   <= '0;
            coeff_high_reg  <= '0;
            busy_reg        <= 1'b0;
            pend_valid_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_STAGE_COUNT: stage_count_reg <= cfg_data[COUNT_W-1:0];
                    REG_COEFF_LOW:   coeff_low_reg   <= cfg_data;
                    REG_COEFF_HIGH:  coeff_high_reg  <= cfg_data;
                    default:         ;
                endcase
            end

            if (accept) begin
                busy_reg <= 1'b1;
            end else if (tail.valid) begin
                busy_reg <= 1'b0;
            end

            if (out_free) begin
                m_valid_reg    <= pend_valid_reg;
                m_sample_reg   <= pend_sample_reg;
                m_last_reg     <= pend_last_reg;
                pend_valid_reg <= 1'b0;
            end

            if (tail.valid) begin
                pend_valid_reg  <= 1'b1;
                pend_sample_reg <= tail.fwd;
                pend_last_reg   <= tail.last;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_sample_out    = m_sample_reg;
    assign m_block_end_out = m_last_reg;

endmodule

### rtl/fll_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// fll_checker
// Port-level checks for the lattice filter, bound to the top level.
// ============================================================================
module fll_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic signed [fll_pkg::SAMPLE_W-1:0]   m_sample_out,
    input logic                                  m_block_end_out
);
    import fll_pkg::*;

    // Out of reset: nothing to send, ready for a word.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("bad state after reset");

    // One word in the chain at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word accepted while chain busy");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_out)
                                && $stable(m_block_end_out))
        else $error("stalled output word changed");

endmodule

bind fir_lattice_q15_filter fll_checker u_fll_checker (.*);
